@@ sv/dsss_pkg.sv @@
`default_nettype none

package dsss_pkg;

    localparam int ACTION_SLOTS = 16;
    localparam int SLOT_W       = $clog2(ACTION_SLOTS);
    localparam int COUNT_W      = 5;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] KIND_PAUSE    = 2'd0;
    localparam logic [1:0] KIND_SCROLL   = 2'd1;
    localparam logic [1:0] KIND_POSITION = 2'd2;

    localparam logic REG_REPEAT = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         entry_index;
        logic [1:0]         action_kind;
        logic signed [15:0] step_or_position;
        logic [15:0]        delay_or_duration;
        logic [7:0]         step_count;
    } item_t;

    typedef struct packed {
        logic signed [15:0] scroll_offset;
        logic               offset_updated;
        logic [3:0]         current_entry;
        logic               script_active;
    } result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] step;
        logic [15:0] delay;
        logic [7:0]  count;
    } slot_t;

    typedef struct packed {
        logic               repeat_enable;
        logic [COUNT_W-1:0] action_count;
    } cfg_t;

    typedef struct packed {
        logic              started;
        logic              running;
        logic [SLOT_W-1:0] entry;
        logic              enter;
    } plan_t;

endpackage

`default_nettype wire

@@ sv/dsss_cfg.sv @@
`default_nettype none

module dsss_cfg import dsss_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic               repeat_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_reg <= 1'b0;
            count_reg  <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_REPEAT: repeat_reg <= pwdata[0];
                REG_COUNT:  count_reg  <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_REPEAT: prdata = {31'd0, repeat_reg};
            REG_COUNT:  prdata = {{(32-COUNT_W){1'b0}}, count_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.repeat_enable = repeat_reg;
    assign cfg.action_count  = count_reg;

endmodule

`default_nettype wire

@@ sv/display_scroll_script_sequencer.sv @@
// Display scroll script sequencer.
// Script entries are loaded through the input channel (load words) and are
// played back by tick words, each of which advances a millisecond time base
// by one and runs one pass of the script: pauses, timed scroll moves and
// absolute position settings. A restart word stops the script so that it
// begins again at entry 0 on the next tick.
// The input channel (s_) and the result channel (m_) use valid/ready; every
// input word gives exactly one result word carrying the offset, the update
// flag, the current entry and the active flag.
// A word's script table entry is read into the slot register when the word is
// accepted, and the pass is evaluated and registered into the result register
// when the word commits. One word is accepted per cycle for as long as the
// result side keeps up; the table read address is taken from the state that
// the word ahead is producing, so consecutive ticks never wait.
// When the receiver stalls, one result waits in the output register and one
// word waits in the evaluation stage; after that s_ready drops.
// Reset clears the script state, time base, offset and both registers of the
// APB port; the script table holds no defined contents until it is loaded.
`default_nettype none

module display_scroll_script_sequencer import dsss_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire item_t       s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output result_t          m_data
);

    cfg_t cfg;

    dsss_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    function automatic plan_t plan_pass(
        input logic               started,
        input logic               running,
        input logic               pending,
        input logic [SLOT_W-1:0]  entry,
        input logic [COUNT_W-1:0] used,
        input logic               rpt
    );
        plan_t             p;
        logic [SLOT_W:0]   nx;
        p.started = started;
        p.running = running;
        p.entry   = entry;
        p.enter   = 1'b0;
        nx        = {1'b0, entry} + (SLOT_W+1)'(1);
        if (!started && used != '0) begin
            p.started = 1'b1;
            p.running = 1'b1;
            p.entry   = '0;
            p.enter   = 1'b1;
        end else if (pending && running) begin
            if (COUNT_W'(nx) >= used) begin
                if (rpt && used != '0) begin
                    p.entry = '0;
                    p.enter = 1'b1;
                end else begin
                    p.running = 1'b0;
                end
            end else begin
                p.entry = nx[SLOT_W-1:0];
                p.enter = 1'b1;
            end
        end
        return p;
    endfunction

    slot_t mem [ACTION_SLOTS];

    logic               started_reg, started_next;
    logic               running_reg, running_next;
    logic               pending_reg, pending_next;
    logic [SLOT_W-1:0]  entry_reg, entry_next;
    logic [31:0]        time_reg, time_next;
    logic [31:0]        mark_reg, mark_next;
    logic [31:0]        move_reg, move_next;
    logic [7:0]         moves_reg, moves_next;
    logic [15:0]        pos_reg, pos_next;

    logic               p1_valid_reg;
    logic [1:0]         p1_op_reg;
    slot_t              slot_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    logic               p1_commit;
    logic               accept;
    logic               upd;
    logic [COUNT_W-1:0] used_n;
    logic [31:0]        tick_time;
    logic [31:0]        delay_ext;
    plan_t              pl;
    plan_t              pl_rd;
    logic [SLOT_W-1:0]  rd_addr;

    assign used_n = (cfg.action_count > COUNT_W'(ACTION_SLOTS)) ?
                    COUNT_W'(ACTION_SLOTS) : cfg.action_count;

    assign p1_commit = p1_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready   = !p1_valid_reg || p1_commit;
    assign accept    = s_valid && s_ready;

    assign tick_time = time_reg + 32'd1;
    assign delay_ext = {16'd0, slot_reg.delay};
    assign pl = plan_pass(started_reg, running_reg, pending_reg, entry_reg, used_n,
                          cfg.repeat_enable);

    always_comb begin
        started_next = started_reg;
        running_next = running_reg;
        pending_next = pending_reg;
        entry_next   = entry_reg;
        time_next    = time_reg;
        mark_next    = mark_reg;
        move_next    = move_reg;
        moves_next   = moves_reg;
        pos_next     = pos_reg;
        upd          = 1'b0;
        if (p1_commit) begin
            case (p1_op_reg)
                OP_TICK: begin
                    time_next    = tick_time;
                    started_next = pl.started;
                    running_next = pl.running;
                    entry_next   = pl.entry;
                    pending_next = 1'b0;
                    if (pl.enter) begin
                        case (slot_reg.kind)
                            KIND_SCROLL: begin
                                mark_next  = tick_time;
                                move_next  = tick_time + delay_ext;
                                moves_next = '0;
                            end
                            KIND_POSITION: ;
                            default: mark_next = tick_time + delay_ext;
                        endcase
                    end
                    if (pl.running) begin
                        case (slot_reg.kind)
                            KIND_SCROLL: begin
                                if (tick_time >= move_next) begin
                                    moves_next = moves_next + 8'd1;
                                    pos_next   = pos_reg + slot_reg.step;
                                    upd        = 1'b1;
                                    if (slot_reg.count != '0 && moves_next == slot_reg.count) begin
                                        pending_next = 1'b1;
                                    end
                                    move_next = move_next + delay_ext;
                                end
                            end
                            KIND_POSITION: begin
                                pos_next     = slot_reg.step;
                                upd          = 1'b1;
                                pending_next = 1'b1;
                            end
                            default: begin
                                if (tick_time >= mark_next) begin
                                    pending_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                OP_RESTART: begin
                    started_next = 1'b0;
                    running_next = 1'b0;
                    pending_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // The next word reads the entry that the state left by the word ahead selects.
    assign pl_rd = plan_pass(started_next, running_next, pending_next, entry_next, used_n,
                             cfg.repeat_enable);
    assign rd_addr = pl_rd.entry;

    always_ff @(posedge aclk) begin
        if (accept && s_data.operation == OP_LOAD) begin
            mem[s_data.entry_index[SLOT_W-1:0]] <= '{kind:  s_data.action_kind,
                                                     step:  s_data.step_or_position,
                                                     delay: s_data.delay_or_duration,
                                                     count: s_data.step_count};
        end
        if (accept) begin
            slot_reg  <= mem[rd_addr];
            p1_op_reg <= s_data.operation;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            running_reg <= 1'b0;
            pending_reg <= 1'b0;
            entry_reg   <= '0;
            time_reg    <= '0;
            mark_reg    <= '0;
            move_reg    <= '0;
            moves_reg   <= '0;
            pos_reg     <= '0;
        end else begin
            started_reg <= started_next;
            running_reg <= running_next;
            pending_reg <= pending_next;
            entry_reg   <= entry_next;
            time_reg    <= time_next;
            mark_reg    <= mark_next;
            move_reg    <= move_next;
            moves_reg   <= moves_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_commit) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_commit) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_commit) begin
            res_reg.scroll_offset  <= pos_next;
            res_reg.offset_updated <= upd;
            res_reg.current_entry  <= entry_next;
            res_reg.script_active  <= running_next;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

    // A running script has always been started.
    a_running_started: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> started_reg)
        else $error("script running without having started");

    // An advance is only ever left pending by a running action.
    a_pending_running: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> running_reg)
        else $error("advance pending while the script is stopped");

    // Only tick words may move or set the offset.
    a_update_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_commit && p1_op_reg != OP_TICK |=> !m_data.offset_updated)
        else $error("offset update reported for a non-tick word");

    // Each committed tick advances the time base by exactly one millisecond.
    a_time_step: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_commit && p1_op_reg == OP_TICK |=> time_reg == $past(time_reg) + 32'd1)
        else $error("time base did not advance by one on a tick");

endmodule

`default_nettype wire

@@ dv/scroll_script_checker.sv @@
module scroll_script_checker
    import dsss_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire item_t       s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire result_t     m_data,
    output int               mismatches,
    output int               pending,
    output int               results_seen,
    output int               offset_moves
);

    cfg_t              regs;
    slot_t             slots [ACTION_SLOTS];
    logic [SLOT_W-1:0] ptr;
    logic              run;
    logic              begun;
    logic              adv;
    logic [31:0]       now_ms;
    logic [31:0]       mark_ms;
    logic [31:0]       next_move_ms;
    logic [7:0]        moves;
    logic [15:0]       offset;

    result_t           results_due [$];

    task automatic enter_slot();
        slot_t s;
        s = slots[ptr];
        if (s.kind == KIND_SCROLL) begin
            mark_ms      = now_ms;
            next_move_ms = now_ms + 32'(s.delay);
            moves        = 8'd0;
        end else if (s.kind != KIND_POSITION) begin
            mark_ms = now_ms + 32'(s.delay);
        end
    endtask

    task automatic play_word(input item_t w, output result_t r);
        slot_t s;
        int    n;
        int    nx;
        logic  moved;
        moved = 1'b0;
        case (w.operation)
            OP_TICK: begin
                now_ms = now_ms + 32'd1;
                n = (regs.action_count > ACTION_SLOTS) ? ACTION_SLOTS : int'(regs.action_count);
                if (!begun && n != 0) begin
                    begun = 1'b1;
                    run   = 1'b1;
                    ptr   = '0;
                    enter_slot();
                    adv   = 1'b0;
                end
                if (adv) begin
                    adv = 1'b0;
                    if (run) begin
                        nx = int'(ptr) + 1;
                        if (nx >= n) begin
                            if (regs.repeat_enable && n != 0) begin
                                ptr = '0;
                            end else begin
                                run = 1'b0;
                            end
                        end else begin
                            ptr = SLOT_W'(nx);
                        end
                        if (run) begin
                            enter_slot();
                        end
                    end
                end
                if (run) begin
                    s = slots[ptr];
                    if (s.kind == KIND_SCROLL) begin
                        if (now_ms >= next_move_ms) begin
                            moves  = moves + 8'd1;
                            offset = offset + s.step;
                            moved  = 1'b1;
                            if (s.count != 8'd0 && moves == s.count) begin
                                adv = 1'b1;
                            end
                            next_move_ms = next_move_ms + 32'(s.delay);
                        end
                    end else if (s.kind == KIND_POSITION) begin
                        offset = s.step;
                        moved  = 1'b1;
                        adv    = 1'b1;
                    end else begin
                        if (now_ms >= mark_ms) begin
                            adv = 1'b1;
                        end
                    end
                end
            end
            OP_LOAD: begin
                slots[w.entry_index].kind  = w.action_kind;
                slots[w.entry_index].step  = w.step_or_position;
                slots[w.entry_index].delay = w.delay_or_duration;
                slots[w.entry_index].count = w.step_count;
            end
            OP_RESTART: begin
                begun = 1'b0;
                run   = 1'b0;
                adv   = 1'b0;
            end
            default: begin
            end
        endcase
        r.scroll_offset  = offset;
        r.offset_updated = moved;
        r.current_entry  = ptr;
        r.script_active  = run;
    endtask

    always @(posedge aclk) begin : watch_channels
        result_t want;
        result_t made;
        if (!aresetn) begin
            regs         = '0;
            ptr          = '0;
            run          = 1'b0;
            begun        = 1'b0;
            adv          = 1'b0;
            now_ms       = '0;
            mark_ms      = '0;
            next_move_ms = '0;
            moves        = '0;
            offset       = '0;
            mismatches   = 0;
            results_seen = 0;
            offset_moves = 0;
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_REPEAT, 2'b00}) begin
                    regs.repeat_enable = pwdata[0];
                end else if (paddr == {REG_COUNT, 2'b00}) begin
                    regs.action_count = pwdata[COUNT_W-1:0];
                end
            end
            // Results are compared before the word of this edge is predicted, as a
            // word never yields its result at the edge at which it is accepted.
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    $error("result word with no input word waiting: %p", m_data);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (want.offset_updated) begin
                        offset_moves++;
                    end
                    if (m_data.scroll_offset !== want.scroll_offset) begin
                        $error("scroll_offset: expected %0d, got %0d",
                               want.scroll_offset, m_data.scroll_offset);
                        mismatches++;
                    end
                    if (m_data.offset_updated !== want.offset_updated) begin
                        $error("offset_updated: expected %0d, got %0d",
                               want.offset_updated, m_data.offset_updated);
                        mismatches++;
                    end
                    if (m_data.current_entry !== want.current_entry) begin
                        $error("current_entry: expected %0d, got %0d",
                               want.current_entry, m_data.current_entry);
                        mismatches++;
                    end
                    if (m_data.script_active !== want.script_active) begin
                        $error("script_active: expected %0d, got %0d",
                               want.script_active, m_data.script_active);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                play_word(s_data, made);
                results_due.push_back(made);
            end
        end
        pending = results_due.size();
    end

endmodule

@@ dv/tb_display_scroll_script_sequencer.sv @@
module tb_display_scroll_script_sequencer;

    import dsss_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int         RANDOM_WORDS = 1050;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    item_t       s_data;
    logic        m_valid;
    logic        m_ready;
    result_t     m_data;

    int          mismatches;
    int          pending;
    int          results_seen;
    int          offset_moves;
    int          words_sent;
    int          ticks_sent;
    int          settings_made;
    bit          calm;

    display_scroll_script_sequencer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    scroll_script_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .offset_moves (offset_moves)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("[display_scroll_script_sequencer] ERROR");
        $finish;
    end

    initial begin : result_side
        int pick;
        int len;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            pick = $urandom_range(0, 99);
            if (calm || pick < 60) begin
                m_ready <= 1'b1;
                len = $urandom_range(1, 8);
            end else if (pick < 95) begin
                m_ready <= 1'b0;
                len = $urandom_range(1, 3);
            end else begin
                m_ready <= 1'b0;
                len = $urandom_range(10, 40);
            end
            repeat (len - 1) @(negedge aclk);
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60) begin
            return 0;
        end else if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic item_t scatter_word(input logic [1:0] op);
        item_t w;
        w.operation         = op;
        w.entry_index       = 4'($urandom);
        w.action_kind       = 2'($urandom);
        w.step_or_position  = 16'($urandom);
        w.delay_or_duration = 16'($urandom);
        w.step_count        = 8'($urandom);
        return w;
    endfunction

    function automatic item_t script_entry_word();
        item_t w;
        int    p;
        w = scatter_word(OP_LOAD);
        p = $urandom_range(0, 99);
        w.action_kind = (p < 30) ? KIND_PAUSE : (p < 70) ? KIND_SCROLL :
                        (p < 92) ? KIND_POSITION : KIND_SPARE;
        p = $urandom_range(0, 99);
        if (p < 85) begin
            w.delay_or_duration = 16'($urandom_range(0, 6));
        end else if (p < 95) begin
            w.delay_or_duration = 16'($urandom_range(7, 40));
        end
        p = $urandom_range(0, 99);
        if (p < 60) begin
            w.step_count = 8'($urandom_range(1, 4));
        end else if (p < 80) begin
            w.step_count = 8'd0;
        end
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so the next word or an idle takes over at that edge.
    task automatic send_word(input item_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (w.operation == OP_TICK) begin
            ticks_sent++;
        end
        @(negedge aclk);
    endtask

    task automatic load_entry(input logic [3:0] idx, input logic [1:0] kind,
                              input logic signed [15:0] step, input logic [15:0] delay,
                              input logic [7:0] count);
        item_t w;
        w.operation         = OP_LOAD;
        w.entry_index       = idx;
        w.action_kind       = kind;
        w.step_or_position  = step;
        w.delay_or_duration = delay;
        w.step_count        = count;
        send_word(w);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_script(input logic rep, input logic [4:0] count);
        wait_idle();
        write_register(REG_REPEAT, {31'd0, rep});
        write_register(REG_COUNT, {27'd0, count});
        settings_made++;
    endtask

    initial begin : stimulus
        int         random_sent;
        int         phase_len;
        int         p;
        int         drain_cycles;
        logic [4:0] count;
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        calm          = 1'b0;
        words_sent    = 0;
        ticks_sent    = 0;
        settings_made = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With no entries in use a tick must not start the script.
        send_word(scatter_word(OP_TICK));
        load_entry(4'd0, KIND_POSITION, 16'sd32767, 16'd0, 8'd0);
        load_entry(4'd1, KIND_SCROLL, -16'sd32768, 16'd0, 8'd3);
        load_entry(4'd2, KIND_PAUSE, 16'sd0, 16'd2, 8'd0);
        load_entry(4'd3, KIND_SPARE, 16'sd5, 16'd1, 8'd255);
        load_entry(4'd4, KIND_SCROLL, 16'sd7, 16'd2, 8'd2);
        load_entry(4'd5, KIND_POSITION, -16'sd32768, 16'd65535, 8'd255);
        load_entry(4'd6, KIND_SCROLL, 16'sd1, 16'd1, 8'd0);
        for (int i = 7; i < 15; i++) begin
            load_entry(4'(i), KIND_PAUSE, 16'sd0, 16'(i % 3), 8'd1);
        end
        load_entry(4'd15, KIND_SCROLL, 16'sd32767, 16'd65535, 8'd255);
        set_script(1'b0, 5'd6);
        repeat (7) send_word(scatter_word(OP_TICK));
        send_word(scatter_word(OP_IGNORED));
        send_word(scatter_word(OP_RESTART));
        send_word(scatter_word(OP_TICK));

        random_sent = 0;
        while (random_sent < RANDOM_WORDS) begin
            p = $urandom_range(0, 99);
            if (p < 15) begin
                count = 5'd0;
            end else if (p < 30) begin
                count = 5'd16;
            end else if (p < 40) begin
                count = 5'($urandom_range(17, 31));
            end else begin
                count = 5'($urandom_range(1, 8));
            end
            set_script(1'($urandom), count);
            calm = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(50, 90);
            for (int k = 0; k < phase_len; k++) begin
                p = $urandom_range(0, 99);
                if (p < 70) begin
                    send_word(scatter_word(OP_TICK));
                end else if (p < 88) begin
                    send_word(script_entry_word());
                end else if (p < 95) begin
                    send_word(scatter_word(OP_RESTART));
                end else begin
                    send_word(scatter_word(OP_IGNORED));
                end
                random_sent++;
            end
        end
        calm = 1'b0;

        s_valid <= 1'b0;
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < 20000) begin
            @(negedge aclk);
            drain_cycles++;
        end
        repeat (8) @(posedge aclk);

        $display("Sent %0d words (%0d ticks) over %0d register settings.",
                 words_sent, ticks_sent, settings_made);
        $display("Compared %0d result words, %0d of them with a moved or set offset.",
                 results_seen, offset_moves);
        if (mismatches == 0 && pending == 0) begin
            $display("[display_scroll_script_sequencer] OK");
        end else begin
            $display("[display_scroll_script_sequencer] ERROR");
        end
        $finish;
    end

endmodule
